// ===== hdl/mandelbrot_escape_time_core_defines.svh =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core assertion macros
// Shared property forms for the checkers of the core.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Word types, constants and helper functions shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package met_pkg;

  localparam int FRAC_BITS_DEFAULT = 28;
  localparam int QUEUE_DEPTH       = 2;
  localparam int CNT_W             = 16;
  localparam int BAND_W            = 3;
  localparam int COORD_W           = 32;
  localparam int PROD_W            = 2 * COORD_W;
  localparam int SCALED_W          = CNT_W + 7;

  localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd256;

  localparam logic [BAND_W-1:0] BAND_INSIDE = 3'd0;
  localparam logic [BAND_W-1:0] BAND_DIV8   = 3'd1;
  localparam logic [BAND_W-1:0] BAND_DIV10  = 3'd2;
  localparam logic [BAND_W-1:0] BAND_DIV20  = 3'd3;
  localparam logic [BAND_W-1:0] BAND_DIV40  = 3'd4;
  localparam logic [BAND_W-1:0] BAND_DIV100 = 3'd5;
  localparam logic [BAND_W-1:0] BAND_OUTER  = 3'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
  } point_t;

  typedef struct packed {
    logic [CNT_W-1:0]  iteration_count;
    logic [BAND_W-1:0] color_band;
  } result_t;

  typedef struct packed {
    point_t           pt;
    logic [CNT_W-1:0] lim;
    logic             zero_lim;
  } job_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [BAND_W-1:0] color_of(input logic [CNT_W-1:0] cnt,
                                                 input logic [CNT_W-1:0] lim);
    logic [SCALED_W-1:0] c;
    logic [SCALED_W-1:0] l;
    c = SCALED_W'(cnt);
    l = SCALED_W'(lim);
    if (cnt >= lim) begin
      return BAND_INSIDE;
    end else if (c * SCALED_W'(8) > l) begin
      return BAND_DIV8;
    end else if (c * SCALED_W'(10) > l) begin
      return BAND_DIV10;
    end else if (c * SCALED_W'(20) > l) begin
      return BAND_DIV20;
    end else if (c * SCALED_W'(40) > l) begin
      return BAND_DIV40;
    end else if (c * SCALED_W'(100) > l) begin
      return BAND_DIV100;
    end
    return BAND_OUTER;
  endfunction

endpackage

// ===== hdl/met_front.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time front end
// Accepts points, tags each with the current limit and queues it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pt_valid,
  output logic                  pt_stall,
  input  met_pkg::point_t       pt,
  input  logic [15:0]           lim,
  output logic                  job_valid,
  input  logic                  job_pop,
  output met_pkg::job_t         job
);
  import met_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  job_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign pt_stall  = (fill == FILL_W'(QUEUE_DEPTH));
  assign push      = pt_valid && !pt_stall;
  assign job_valid = (fill != '0);
  assign pop       = job_pop && job_valid;
  assign job       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{pt: pt, lim: lim, zero_lim: (lim == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// ===== hdl/met_engine.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time iteration engine
// Iterates z = z*z + c for one point at a time and holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_engine #(
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_pop,
  input  met_pkg::job_t     job,
  output logic              res_valid,
  input  logic              res_stall,
  output met_pkg::result_t  res
);
  import met_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [PROD_W-1:0] FOUR = PROD_W'(4) << FRAC_BITS;

  logic [1:0]                state;
  logic signed [COORD_W-1:0] zr;
  logic signed [COORD_W-1:0] zi;
  logic signed [COORD_W-1:0] cr;
  logic signed [COORD_W-1:0] ci;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          lim;
  logic signed [PROD_W-1:0]  prr;
  logic signed [PROD_W-1:0]  pii;
  logic signed [PROD_W-1:0]  pri;

  logic [PROD_W-1:0]         mag;
  logic                      go_on;
  logic signed [PROD_W-1:0]  nr;
  logic signed [PROD_W-1:0]  ni;
  logic                      out_free;

  assign mag      = ($unsigned(prr) >> FRAC_BITS) + ($unsigned(pii) >> FRAC_BITS);
  assign go_on    = (count < lim) && (mag <= FOUR);
  assign nr       = ((prr - pii) >>> FRAC_BITS) + PROD_W'(cr);
  assign ni       = (pri >>> (FRAC_BITS - 1)) + PROD_W'(ci);
  assign out_free = !res_valid || !res_stall;
  assign job_pop  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        zr    <= '0;
        zi    <= '0;
        cr    <= job.pt.c_real;
        ci    <= job.pt.c_imag;
        count <= '0;
        lim   <= job.lim;
      end
      ST_MUL: begin
        prr <= PROD_W'(zr) * PROD_W'(zr);
        pii <= PROD_W'(zi) * PROD_W'(zi);
        pri <= PROD_W'(zr) * PROD_W'(zi);
      end
      ST_STEP: begin
        if (go_on) begin
          zr    <= sat32(nr);
          zi    <= sat32(ni);
          count <= count + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          res <= '{iteration_count: count, color_band: color_of(count, lim)};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= job.zero_lim ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_STEP;
        end
        ST_STEP: begin
          state <= go_on ? ST_MUL : ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/mandelbrot_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core
// Counts escape iterations of fixed-point points and picks a color band.
// ----------------------------------------------------------------------------
// A point word enters on pt with pt_valid; the core raises pt_stall when its
// two-entry point queue is full. Each point yields one result word on res
// with res_valid, held steady while res_stall is high.
// The iteration limit is written through cfg_valid, cfg_ready and cfg_data;
// the user must write it only while no point is in flight, as the core does
// not enforce this. cfg_ready is always high. Each iteration first registers
// the three 32 by 32 products in ST_MUL, then runs the escape test and the
// update of z in ST_STEP. Points are worked on one at a time; the engine
// takes the next point from the queue only while it is in ST_IDLE.
// The next points wait in the queue while a result waits to be taken.
// Reset sets the limit to 256 and drops all queued and in-flight points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pt_valid,
  output logic              pt_stall,
  input  met_pkg::point_t   pt,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  output logic              res_valid,
  input  logic              res_stall,
  output met_pkg::result_t  res
);
  import met_pkg::*;

  logic [CNT_W-1:0] max_iterations;
  logic             job_valid;
  logic             job_pop;
  job_t             job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_iterations <= cfg_data;
    end
  end

  met_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt        (pt),
    .lim       (max_iterations),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  met_engine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== hdl/met_checker.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_core_defines.svh"

module met_checker (
  input logic              clk,
  input logic              rst,
  input logic              pt_valid,
  input logic              pt_stall,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [15:0]       cfg_data,
  input logic              res_valid,
  input logic              res_stall,
  input met_pkg::result_t  res
);
  import met_pkg::*;

  logic [2:0]       outstanding;
  logic [CNT_W-1:0] lim_seen;
  logic             pt_take;
  logic             res_take;

  assign pt_take  = pt_valid && !pt_stall;
  assign res_take = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      lim_seen    <= MAX_ITER_RESET;
    end else begin
      if (pt_take && !res_take) begin
        outstanding <= outstanding + 3'd1;
      end else if (res_take && !pt_take) begin
        outstanding <= outstanding - 3'd1;
      end
      if (cfg_valid && cfg_ready) begin
        lim_seen <= cfg_data;
      end
    end
  end

  `MET_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "Stalled result word changed.")
  `MET_ASSERT_NOW(a_no_orphan, res_valid, outstanding != 3'd0, "Result word without a pending point.")
  `MET_ASSERT_NOW(a_count_limit, res_valid, res.iteration_count <= lim_seen, "Count exceeds the limit.")
  `MET_ASSERT_NOW(a_zero_band, res_valid && res.iteration_count == '0, res.color_band == BAND_INSIDE || res.color_band == BAND_OUTER, "Zero count with a middle band.")

endmodule

bind mandelbrot_escape_time_core met_checker u_checker (.*);
